>>> rtl/core/md5he_pkg.sv
package md5he_pkg;

    // Initial chaining words of MD5.
    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hEFCDAB89;
    localparam logic [31:0] IV_C = 32'h98BADCFE;
    localparam logic [31:0] IV_D = 32'h10325476;

    // Padding marker byte and the byte position at which the length field starts.
    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [5:0] LEN_POS   = 6'd56;
    localparam logic [5:0] LAST_POS  = 6'd63;
    localparam logic [5:0] LAST_RND  = 6'd63;
    localparam logic [4:0] LEN_LO_W  = 5'd14;
    localparam logic [4:0] LEN_HI_W  = 5'd15;
    localparam logic [4:0] PAST_BLK  = 5'd16;

    // Depth of the word queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One queued word.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_item;

    // Queue head as seen by the back part.
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_head;

    // Per-round additive constants.
    localparam logic [31:0] SINE [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Left rotation amount of a round.
    function automatic logic [4:0] rot_amt(input logic [5:0] rnd);
        logic [4:0] s;
        case ({rnd[5:4], rnd[1:0]})
            4'd0:    s = 5'd7;
            4'd1:    s = 5'd12;
            4'd2:    s = 5'd17;
            4'd3:    s = 5'd22;
            4'd4:    s = 5'd5;
            4'd5:    s = 5'd9;
            4'd6:    s = 5'd14;
            4'd7:    s = 5'd20;
            4'd8:    s = 5'd4;
            4'd9:    s = 5'd11;
            4'd10:   s = 5'd16;
            4'd11:   s = 5'd23;
            4'd12:   s = 5'd6;
            4'd13:   s = 5'd10;
            4'd14:   s = 5'd15;
            default: s = 5'd21;
        endcase
        return s;
    endfunction

    // Index of the block word that a round reads.
    function automatic logic [3:0] msg_idx(input logic [5:0] rnd);
        logic [3:0] r4;
        logic [3:0] g;
        r4 = rnd[3:0];
        case (rnd[5:4])
            2'd0:    g = r4;
            2'd1:    g = {r4[1:0], 2'b00} + r4 + 4'd1;
            2'd2:    g = {r4[2:0], 1'b0} + r4 + 4'd5;
            default: g = {r4[0], 3'b000} - r4;
        endcase
        return g;
    endfunction

endpackage

>>> rtl/core/md5he_front.sv
module md5he_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  md5he_pkg::t_item    i_item,
    input  logic                i_pop,
    output md5he_pkg::t_q_head  o_head
);

    md5he_pkg::t_item                   r_mem [md5he_pkg::QUEUE_DEPTH];
    logic [md5he_pkg::QPTR_W-1:0]       r_wptr;
    logic [md5he_pkg::QPTR_W-1:0]       r_rptr;
    logic [md5he_pkg::QCNT_W-1:0]       r_count;
    logic                               push;
    logic                               pop;

    // Words with neither a byte nor an end mark are taken and dropped here.
    assign o_ready = (r_count != md5he_pkg::QCNT_W'(md5he_pkg::QUEUE_DEPTH));
    assign push    = i_valid && o_ready && (i_item.byte_present || i_item.end_of_message);
    assign pop     = i_pop && (r_count != '0);

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rptr];

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == md5he_pkg::QPTR_W'(md5he_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == md5he_pkg::QPTR_W'(md5he_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

>>> rtl/core/md5he_round.sv
module md5he_round (
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [31:0] i_c,
    input  logic [31:0] i_d,
    input  logic [31:0] i_m,
    input  logic [5:0]  i_rnd,
    output logic [31:0] o_t
);

    logic [31:0] f;
    logic [31:0] sum;
    logic [63:0] dbl;

    // Round function by quarter.
    always_comb begin
        case (i_rnd[5:4])
            2'd0:    f = (i_b & i_c) | (~i_b & i_d);
            2'd1:    f = (i_d & i_b) | (~i_d & i_c);
            2'd2:    f = i_b ^ i_c ^ i_d;
            default: f = i_c ^ (i_b | ~i_d);
        endcase
    end

    // Add, rotate left and add the previous B.
    assign sum = i_a + f + md5he_pkg::SINE[i_rnd] + i_m;
    assign dbl = {sum, sum} << md5he_pkg::rot_amt(i_rnd);
    assign o_t = i_b + dbl[63:32];

endmodule

>>> rtl/core/md5he_back.sv
module md5he_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  md5he_pkg::t_q_head  i_head,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [31:0]         o_digest_word_a,
    output logic [31:0]         o_digest_word_b,
    output logic [31:0]         o_digest_word_c,
    output logic [31:0]         o_digest_word_d
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PAD0  = 7'b0000010,
        S_FILL  = 7'b0000100,
        S_CINIT = 7'b0001000,
        S_COMP  = 7'b0010000,
        S_ADD   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state      r_state;
    t_state      n_state;
    logic [31:0] r_buf [16];
    logic [31:0] r_cv [4];
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [63:0] r_len;
    logic [5:0]  r_rnd;
    logic [4:0]  r_widx;
    logic        r_padding;
    logic        r_last;
    logic        r_eom_pend;
    logic [5:0]  pos;
    logic [31:0] round_t;
    logic [31:0] pad_word;
    logic [31:0] fill_word;

    assign pos   = r_len[8:3];
    assign o_pop = (r_state == S_IDLE) && i_head.valid;

    md5he_round u_round (
        .i_a   (r_a),
        .i_b   (r_b),
        .i_c   (r_c),
        .i_d   (r_d),
        .i_m   (r_buf[md5he_pkg::msg_idx(r_rnd)]),
        .i_rnd (r_rnd),
        .o_t   (round_t)
    );

    // Word holding the pad marker: lower bytes kept, marker, upper bytes cleared.
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            if (j < int'(pos[1:0])) begin
                pad_word[j*8 +: 8] = r_buf[pos[5:2]][j*8 +: 8];
            end else if (j == int'(pos[1:0])) begin
                pad_word[j*8 +: 8] = md5he_pkg::PAD_BYTE;
            end else begin
                pad_word[j*8 +: 8] = 8'h00;
            end
        end
    end

    // Fill word: zero, or the bit length in the last two words of the final block.
    always_comb begin
        fill_word = '0;
        if (r_last && (r_widx == md5he_pkg::LEN_LO_W)) begin
            fill_word = r_len[31:0];
        end else if (r_last && (r_widx == md5he_pkg::LEN_HI_W)) begin
            fill_word = r_len[63:32];
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    if (i_head.item.byte_present && (pos == md5he_pkg::LAST_POS)) begin
                        n_state = S_CINIT;
                    end else if (i_head.item.end_of_message) begin
                        n_state = S_PAD0;
                    end
                end
            end
            S_PAD0:  n_state = S_FILL;
            S_FILL: begin
                if ((r_widx == md5he_pkg::PAST_BLK) || (r_widx == md5he_pkg::LEN_HI_W)) begin
                    n_state = S_CINIT;
                end
            end
            S_CINIT: n_state = S_COMP;
            S_COMP: begin
                if (r_rnd == md5he_pkg::LAST_RND) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                if (r_padding) begin
                    n_state = r_last ? S_OUT : S_FILL;
                end else begin
                    n_state = r_eom_pend ? S_PAD0 : S_IDLE;
                end
            end
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state, chaining words and length.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cv[0]    <= md5he_pkg::IV_A;
            r_cv[1]    <= md5he_pkg::IV_B;
            r_cv[2]    <= md5he_pkg::IV_C;
            r_cv[3]    <= md5he_pkg::IV_D;
            r_len      <= '0;
            r_rnd      <= '0;
            r_widx     <= '0;
            r_padding  <= 1'b0;
            r_last     <= 1'b0;
            r_eom_pend <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (i_head.valid) begin
                        r_eom_pend <= i_head.item.end_of_message;
                        if (i_head.item.byte_present) begin
                            r_len <= r_len + 64'd8;
                        end
                    end
                end
                S_PAD0: begin
                    r_padding <= 1'b1;
                    r_last    <= (pos < md5he_pkg::LEN_POS);
                    r_widx    <= {1'b0, pos[5:2]} + 5'd1;
                end
                S_FILL: begin
                    if (r_widx != md5he_pkg::PAST_BLK) begin
                        r_widx <= r_widx + 5'd1;
                    end
                end
                S_CINIT: r_rnd <= '0;
                S_COMP:  r_rnd <= r_rnd + 6'd1;
                S_ADD: begin
                    r_cv[0] <= r_cv[0] + r_a;
                    r_cv[1] <= r_cv[1] + r_b;
                    r_cv[2] <= r_cv[2] + r_c;
                    r_cv[3] <= r_cv[3] + r_d;
                    if (r_padding && !r_last) begin
                        r_last <= 1'b1;
                        r_widx <= '0;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_cv[0]    <= md5he_pkg::IV_A;
                        r_cv[1]    <= md5he_pkg::IV_B;
                        r_cv[2]    <= md5he_pkg::IV_C;
                        r_cv[3]    <= md5he_pkg::IV_D;
                        r_len      <= '0;
                        r_padding  <= 1'b0;
                        r_last     <= 1'b0;
                        r_eom_pend <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Working variables of the compression.
    always_ff @(posedge i_clk) begin
        if (r_state == S_CINIT) begin
            r_a <= r_cv[0];
            r_b <= r_cv[1];
            r_c <= r_cv[2];
            r_d <= r_cv[3];
        end else if (r_state == S_COMP) begin
            r_a <= r_d;
            r_d <= r_c;
            r_c <= r_b;
            r_b <= round_t;
        end
    end

    // Block buffer writes: message bytes, pad marker word and fill words.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_head.valid && i_head.item.byte_present) begin
            r_buf[pos[5:2]][pos[1:0]*8 +: 8] <= i_head.item.data_byte;
        end else if (r_state == S_PAD0) begin
            r_buf[pos[5:2]] <= pad_word;
        end else if ((r_state == S_FILL) && (r_widx != md5he_pkg::PAST_BLK)) begin
            r_buf[r_widx[3:0]] <= fill_word;
        end
    end

    assign o_valid         = (r_state == S_OUT);
    assign o_digest_word_a = r_cv[0];
    assign o_digest_word_b = r_cv[1];
    assign o_digest_word_c = r_cv[2];
    assign o_digest_word_d = r_cv[3];

endmodule

>>> rtl/core/md5_hash_engine_core.sv
// Channel  | Direction | Handshake          | Words
// input    | in        | i_valid / o_ready  | i_data_byte, i_byte_present, i_end_of_message
// output   | out       | o_valid / i_ready  | o_digest_word_a .. o_digest_word_d
//
// A byte word leaves the queue while the back part is idle; the 64th byte of a block adds a
// compression (load, 64 rounds of the single round unit, add).
// An end mark costs padding plus one or two compressions before the digest is
// offered.
// A two-word queue keeps taking input while the back part compresses or a digest
// stalls, and holds off the sender once both entries are in use.
// Reset is synchronous and active low; it needs no clearing pass.
module md5_hash_engine_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word_a,
    output logic [31:0] o_digest_word_b,
    output logic [31:0] o_digest_word_c,
    output logic [31:0] o_digest_word_d
);

    md5he_pkg::t_item   in_item;
    md5he_pkg::t_q_head q_head;
    logic               q_pop;

    assign in_item.data_byte      = i_data_byte;
    assign in_item.byte_present   = i_byte_present;
    assign in_item.end_of_message = i_end_of_message;

    // Front part: accepts and queues words.
    md5he_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (in_item),
        .i_pop   (q_pop),
        .o_head  (q_head)
    );

    // Back part: packs, pads, compresses and presents the digest.
    md5he_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (q_head),
        .o_pop           (q_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_digest_word_a (o_digest_word_a),
        .o_digest_word_b (o_digest_word_b),
        .o_digest_word_c (o_digest_word_c),
        .o_digest_word_d (o_digest_word_d)
    );

endmodule

>>> rtl/core/md5he_checker.sv
module md5he_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_digest_word_a,
    input logic [31:0] o_digest_word_d
);

    // A digest waiting for the consumer stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("digest withdrawn before it was taken");

    // A stalled digest keeps the value of its words A and D.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_digest_word_a) && $stable(o_digest_word_d))
        else $error("digest changed while stalled");

    // No digest is offered straight after reset.
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("digest offered after reset");

    // The queue is empty and takes words straight after reset.
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_ready)
        else $error("input not ready after reset");

endmodule

bind md5_hash_engine_core md5he_checker u_md5he_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_digest_word_a (o_digest_word_a),
    .o_digest_word_d (o_digest_word_d)
);

>>> tb/sv/tb_md5_hash_engine_core.sv
module tb_md5_hash_engine_core;

    // Digest of one message as the block reports it.
    typedef struct {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } t_digest;

    // Running MD5 of the bytes accepted so far, with a queue of expected digests.
    class md5_digest_board;
        logic [31:0] chain [4];
        logic [31:0] blk [16];
        logic [63:0] bit_len;
        t_digest     pending [$];
        int          n_fail;
        int          n_digests;
        int          n_words;

        function void restart();
            chain[0] = md5he_pkg::IV_A;
            chain[1] = md5he_pkg::IV_B;
            chain[2] = md5he_pkg::IV_C;
            chain[3] = md5he_pkg::IV_D;
            foreach (blk[i]) blk[i] = '0;
            bit_len = '0;
        endfunction

        function void put_byte(int pos, logic [7:0] v);
            blk[pos / 4][(pos % 4) * 8 +: 8] = v;
        endfunction

        function logic [31:0] shift_of(int r);
            int sh [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
            return sh[(r / 16) * 4 + (r % 4)];
        endfunction

        // One 64-round compression folded into the chaining words.
        function void compress();
            logic [31:0] a, b, c, d, f, t, s;
            int g;
            a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
            for (int r = 0; r < 64; r++) begin
                if (r < 16) begin
                    f = (b & c) | (~b & d); g = r;
                end else if (r < 32) begin
                    f = (d & b) | (~d & c); g = (5 * r + 1) % 16;
                end else if (r < 48) begin
                    f = b ^ c ^ d; g = (3 * r + 5) % 16;
                end else begin
                    f = c ^ (b | ~d); g = (7 * r) % 16;
                end
                s = a + f + md5he_pkg::SINE[r] + blk[g];
                t = b + ((s << shift_of(r)) | (s >> (32 - shift_of(r))));
                a = d; d = c; c = b; b = t;
            end
            chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
        endfunction

        function new();
            restart();
            n_fail = 0;
            n_digests = 0;
            n_words = 0;
        endfunction

        // Notes an accepted input word and queues a digest when the message ends.
        function void note_word(logic [7:0] data, logic present, logic last);
            int pos;
            t_digest dg;
            n_words++;
            if (present) begin
                pos = int'(bit_len[8:3]);
                put_byte(pos, data);
                bit_len += 8;
                if (pos == 63) compress();
            end
            if (last) begin
                pos = int'(bit_len[8:3]);
                put_byte(pos, md5he_pkg::PAD_BYTE);
                pos++;
                if (pos > 56) begin
                    while (pos < 64) begin
                        put_byte(pos, 8'h00);
                        pos++;
                    end
                    compress();
                    pos = 0;
                end
                while (pos < 56) begin
                    put_byte(pos, 8'h00);
                    pos++;
                end
                blk[14] = bit_len[31:0];
                blk[15] = bit_len[63:32];
                compress();
                dg.a = chain[0]; dg.b = chain[1]; dg.c = chain[2]; dg.d = chain[3];
                pending = {pending, dg};
                restart();
            end
        endfunction

        // Compares a delivered digest with the oldest one expected.
        function void check_digest(t_digest act);
            t_digest exp;
            n_digests++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected digest %h %h %h %h", $time,
                         act.a, act.b, act.c, act.d);
                n_fail++;
                return;
            end
            exp = pending.pop_front();
            if (act.a !== exp.a) begin
                $display("%0t: word A expected %h actual %h", $time, exp.a, act.a);
                n_fail++;
            end
            if (act.b !== exp.b) begin
                $display("%0t: word B expected %h actual %h", $time, exp.b, act.b);
                n_fail++;
            end
            if (act.c !== exp.c) begin
                $display("%0t: word C expected %h actual %h", $time, exp.c, act.c);
                n_fail++;
            end
            if (act.d !== exp.d) begin
                $display("%0t: word D expected %h actual %h", $time, exp.d, act.d);
                n_fail++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte = '0;
    logic        i_byte_present = 1'b0;
    logic        i_end_of_message = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_digest_word_a;
    logic [31:0] o_digest_word_b;
    logic [31:0] o_digest_word_c;
    logic [31:0] o_digest_word_d;

    md5_digest_board board = new();
    int  burst_left = 0;
    bit  hold_off = 1'b0;
    bit  stim_done = 1'b0;

    md5_hash_engine_core uut (.*);

    always #5 i_clk = ~i_clk;

    // Sends one word, honouring bursts and gaps; valid stays up across a burst.
    task automatic send_word(input logic [7:0] data, input logic present, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid          <= 1'b1;
        i_data_byte      <= data;
        i_byte_present   <= present;
        i_end_of_message <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        board.note_word(data, present, last);
    endtask

    // Sends a whole message of n bytes, with some idle words mixed in when noisy is set.
    task automatic send_message(input int n, input bit last_carries_byte, input bit noisy);
        for (int k = 0; k < n; k++) begin
            if (noisy && $urandom_range(0, 15) == 0)
                send_word(8'($urandom), 1'b0, 1'b0);
            if (k == n - 1 && last_carries_byte)
                send_word(8'($urandom), 1'b1, 1'b1);
            else
                send_word(8'($urandom), 1'b1, 1'b0);
        end
        if (!(n > 0 && last_carries_byte))
            send_word(8'($urandom), 1'b0, 1'b1);
    endtask

    // Receiver stall pattern, with one long hold-off requested by the stimulus.
    always @(posedge i_clk) begin
        if (hold_off)
            i_ready <= 1'b0;
        else
            i_ready <= ($urandom_range(0, 99) < 70) || stim_done;
    end

    // Digest checking on every accepted result.
    always @(posedge i_clk) begin
        t_digest act;
        if (i_rst_n && o_valid && i_ready) begin
            act.a = o_digest_word_a;
            act.b = o_digest_word_b;
            act.c = o_digest_word_c;
            act.d = o_digest_word_d;
            board.check_digest(act);
        end
    end

    initial begin
        int lens [12] = '{0, 1, 3, 55, 56, 57, 63, 64, 65, 119, 120, 128};
        int wait_cycles;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty message, all-ones and all-zero bytes, idle word, padding edges.
        send_word(8'hff, 1'b0, 1'b1);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'hff, 1'b1, 1'b1);
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'haa, 1'b0, 1'b1);
        foreach (lens[i])
            send_message(lens[i], 1'(lens[i] % 2), 1'b0);

        // Long receiver hold-off while short messages keep arriving.
        fork
            begin
                hold_off = 1'b1;
                repeat (1500) @(posedge i_clk);
                hold_off = 1'b0;
            end
            for (int m = 0; m < 6; m++)
                send_message(int'($urandom_range(0, 4)), 1'($urandom_range(0, 1)), 1'b0);
        join

        // Random messages, mostly short, sometimes across block edges.
        while (board.n_words < 1750) begin
            if ($urandom_range(0, 9) == 0)
                send_message(int'($urandom_range(50, 140)), 1'($urandom_range(0, 1)), 1'b1);
            else
                send_message(int'($urandom_range(0, 20)), 1'($urandom_range(0, 1)), 1'b1);
        end
        i_valid <= 1'b0;
        stim_done = 1'b1;

        wait_cycles = 0;
        while (board.pending.size() != 0 && wait_cycles < 20000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (200) @(posedge i_clk);
        $display("Sent %0d input words, checked %0d digests, including padding edges",
                 board.n_words, board.n_digests);
        $display("and a long output stall that filled the input queue.");
        if (board.n_fail == 0 && board.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #20000000;
        $display("Timeout with %0d digests outstanding", board.pending.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
